// ===== rtl/core/sapq_pkg.sv =====
`timescale 1ns / 1ps

package sapq_pkg;

  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int DATA_W = 32;

  localparam logic signed [DATA_W-1:0] NONE_VALUE = -32'sd1;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/sapq_cell.sv =====
`timescale 1ns / 1ps

module sapq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                             clk,
  input  sapq_pkg::cell_ctrl_t             ctrl,
  input  logic [CW-1:0]                    count,
  input  logic                             up_ge,
  input  logic signed [sapq_pkg::DATA_W-1:0] up_data,
  input  logic signed [sapq_pkg::DATA_W-1:0] dn_data,
  output logic signed [sapq_pkg::DATA_W-1:0] data,
  output logic                             ge
);

  logic occupied;

  assign occupied = count > CW'(IDX);

  // entries are held largest first, so the cells that stay put on an enqueue form a prefix
  assign ge = occupied && ($signed(data) >= $signed(ctrl.value));

  always_ff @(posedge clk) begin
    if (ctrl.enq) begin
      if (!ge) begin
        if (up_ge) begin
          data <= ctrl.value;
        end else begin
          data <= up_data;
        end
      end
    end else if (ctrl.deq) begin
      data <= dn_data;
    end
  end

endmodule

// ===== rtl/core/sorted_array_priority_queue.sv =====
`timescale 1ns / 1ps

// Max priority queue of signed 32-bit values held in a chain of DEPTH cells,
// largest entry in the first cell. Commands arrive on the cmd channel
// (cmd_valid/cmd_ready): enqueue, dequeue or clear, with a value for enqueue.
// Every transaction yields exactly one result on the res channel
// (res_valid/res_ready): removed value, status, count, nonempty flag and a
// peek at the top after the command.
// All cells compare against the incoming value in parallel and shift by one
// place in the same cycle, so one command is accepted every cycle unless the
// receiver stalls; the result appears in the output register in the cycle
// after acceptance. The output register is the only buffer: a new command is
// taken when it is empty or is being emptied in the same cycle, so a stalled
// receiver holds back the cmd channel.
// Reset empties the queue and the output register; cell contents are not
// cleared and are never read until written again.
// An enqueue on a full queue leaves the queue unchanged and reports full; a
// dequeue on an empty queue reports empty with removed value -1.
module sorted_array_priority_queue #(
  parameter int DEPTH    = 16,
  localparam int CW      = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  logic [1:0]                       command,
  input  logic signed [sapq_pkg::DATA_W-1:0] value,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic signed [sapq_pkg::DATA_W-1:0] removed_value,
  output logic [1:0]                       status,
  output logic [CW-1:0]                    count,
  output logic                             nonempty,
  output logic signed [sapq_pkg::DATA_W-1:0] top_value
);

  logic [CW-1:0]                    entry_count;
  logic [CW-1:0]                    entry_count_next;
  logic                             accept;
  logic                             is_enq;
  logic                             is_deq;
  logic                             is_clr;
  logic                             full;
  logic                             empty;
  logic [1:0]                       status_next;
  logic signed [sapq_pkg::DATA_W-1:0] removed_next;
  logic signed [sapq_pkg::DATA_W-1:0] head_next;
  logic signed [sapq_pkg::DATA_W-1:0] top_next;
  sapq_pkg::cell_ctrl_t             ctrl;

  logic signed [sapq_pkg::DATA_W-1:0] cell_data [DEPTH];
  logic                             cell_ge   [DEPTH];

  assign cmd_ready = !res_valid || res_ready;
  assign accept    = cmd_valid && cmd_ready;

  assign is_enq = command == sapq_pkg::CMD_ENQUEUE;
  assign is_deq = command == sapq_pkg::CMD_DEQUEUE;
  assign is_clr = command == sapq_pkg::CMD_CLEAR;
  assign full   = entry_count == CW'(DEPTH);
  assign empty  = entry_count == '0;

  assign ctrl.enq   = accept && is_enq && !full;
  assign ctrl.deq   = accept && is_deq && !empty;
  assign ctrl.value = value;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                             up_ge;
      logic signed [sapq_pkg::DATA_W-1:0] up_data;
      logic signed [sapq_pkg::DATA_W-1:0] dn_data;

      if (i == 0) begin : g_first
        assign up_ge   = 1'b1;
        assign up_data = sapq_pkg::NONE_VALUE;
      end else begin : g_mid
        assign up_ge   = cell_ge[i-1];
        assign up_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign dn_data = cell_data[i];
      end else begin : g_inner
        assign dn_data = cell_data[i+1];
      end

      sapq_cell #(
        .IDX (i),
        .CW  (CW)
      ) u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .count   (entry_count),
        .up_ge   (up_ge),
        .up_data (up_data),
        .dn_data (dn_data),
        .data    (cell_data[i]),
        .ge      (cell_ge[i])
      );
    end
  endgenerate

  always_comb begin
    entry_count_next = entry_count;
    status_next      = sapq_pkg::ST_OK;
    removed_next     = sapq_pkg::NONE_VALUE;
    head_next        = cell_data[0];
    if (is_enq) begin
      if (full) begin
        status_next = sapq_pkg::ST_FULL;
      end else begin
        entry_count_next = entry_count + CW'(1);
        if (!cell_ge[0]) begin
          head_next = value;
        end
      end
    end else if (is_deq) begin
      if (empty) begin
        status_next = sapq_pkg::ST_EMPTY;
      end else begin
        entry_count_next = entry_count - CW'(1);
        removed_next     = cell_data[0];
        head_next        = cell_data[1];
      end
    end else if (is_clr) begin
      entry_count_next = '0;
    end
    top_next = (entry_count_next == '0) ? sapq_pkg::NONE_VALUE : head_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (accept) begin
        entry_count <= entry_count_next;
        res_valid   <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      removed_value <= removed_next;
      status        <= status_next;
      count         <= entry_count_next;
      nonempty      <= entry_count_next != '0;
      top_value     <= top_next;
    end
  end

endmodule

// ===== dv/pq_order_monitor.sv =====
`timescale 1ns / 1ps

module pq_order_monitor #(
  parameter int DEPTH = 16,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  input  logic                               cmd_ready,
  input  logic [1:0]                         command,
  input  logic signed [sapq_pkg::DATA_W-1:0] value,
  input  logic                               res_valid,
  input  logic                               res_ready,
  input  logic signed [sapq_pkg::DATA_W-1:0] removed_value,
  input  logic [1:0]                         status,
  input  logic [CW-1:0]                      count,
  input  logic                               nonempty,
  input  logic signed [sapq_pkg::DATA_W-1:0] top_value,
  output int                                 fail_count,
  output int                                 outstanding
);

  typedef struct packed {
    logic signed [sapq_pkg::DATA_W-1:0] removed;
    logic [1:0]                         status;
    logic [CW-1:0]                      count;
    logic                               nonempty;
    logic signed [sapq_pkg::DATA_W-1:0] top;
  } pq_result_t;

  // ascending order, largest entry at index held-1
  logic signed [sapq_pkg::DATA_W-1:0] sorted_vals [DEPTH];
  int                                 held;
  pq_result_t                         awaited_q [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    held        = 0;
  end

  function automatic pq_result_t apply_command(
    input logic [1:0]                         cmd,
    input logic signed [sapq_pkg::DATA_W-1:0] val
  );
    pq_result_t r;
    int         pos;
    r.removed = sapq_pkg::NONE_VALUE;
    r.status  = sapq_pkg::ST_OK;
    case (cmd)
      sapq_pkg::CMD_ENQUEUE: begin
        if (held >= DEPTH) begin
          r.status = sapq_pkg::ST_FULL;
        end else begin
          // new value goes below every entry that is greater or equal
          pos = held;
          while (pos > 0 && sorted_vals[pos-1] >= val) begin
            sorted_vals[pos] = sorted_vals[pos-1];
            pos--;
          end
          sorted_vals[pos] = val;
          held++;
        end
      end
      sapq_pkg::CMD_DEQUEUE: begin
        if (held == 0) begin
          r.status = sapq_pkg::ST_EMPTY;
        end else begin
          held--;
          r.removed = sorted_vals[held];
        end
      end
      sapq_pkg::CMD_CLEAR: held = 0;
      default: ;
    endcase
    r.count    = CW'(held);
    r.nonempty = (held > 0);
    r.top      = (held > 0) ? sorted_vals[held-1] : sapq_pkg::NONE_VALUE;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: MISMATCH %s", $time, msg);
  endtask

  always @(posedge clk) begin : compare_proc
    pq_result_t want;
    if (rst) begin
      held = 0;
      awaited_q.delete();
      outstanding <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (awaited_q.size() == 0) begin
          note_failure("result transaction with nothing outstanding");
        end else begin
          want = awaited_q.pop_front();
          if (removed_value !== want.removed || status !== want.status ||
              count !== want.count || nonempty !== want.nonempty ||
              top_value !== want.top) begin
            note_failure($sformatf(
              "exp removed %0d status %0d count %0d nonempty %0d top %0d / got %0d %0d %0d %0d %0d",
              want.removed, want.status, want.count, want.nonempty, want.top,
              removed_value, status, count, nonempty, top_value));
          end
        end
      end
      // a command's result never leaves in the cycle it is taken, so pop before push
      if (cmd_valid && cmd_ready) awaited_q.push_back(apply_command(command, value));
      outstanding <= awaited_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int QDEPTH = 16;
  localparam int CW     = $clog2(QDEPTH + 1);
  localparam int DW     = sapq_pkg::DATA_W;
  localparam int RANDOM_ITEMS = 1300;

  // command code with no meaning, must act as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cmd_valid = 1'b0;
  logic                     cmd_ready;
  logic [1:0]               command = sapq_pkg::CMD_ENQUEUE;
  logic signed [DW-1:0]     value = '0;
  logic                     res_valid;
  logic                     res_ready = 1'b0;
  logic signed [DW-1:0]     removed_value;
  logic [1:0]               status;
  logic [CW-1:0]            count;
  logic                     nonempty;
  logic signed [DW-1:0]     top_value;
  int                       fail_count;
  int                       outstanding;

  sorted_array_priority_queue #(.DEPTH(QDEPTH)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .command      (command),
    .value        (value),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .removed_value(removed_value),
    .status       (status),
    .count        (count),
    .nonempty     (nonempty),
    .top_value    (top_value)
  );

  pq_order_monitor #(.DEPTH(QDEPTH)) i_pq_monitor (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .command      (command),
    .value        (value),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .removed_value(removed_value),
    .status       (status),
    .count        (count),
    .nonempty     (nonempty),
    .top_value    (top_value),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic offer(input logic [1:0] c, input logic signed [DW-1:0] v);
    cmd_valid <= 1'b1;
    command   <= c;
    value     <= v;
    do @(posedge clk); while (!cmd_ready);
  endtask

  // n must be at least one so valid is never lowered and raised in one step
  task automatic idle_for(input int n);
    cmd_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic signed [DW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom;
    // narrow range so equal values meet often
    if (r < 65) return DW'(int'($urandom_range(0, 8)) - 4);
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return sapq_pkg::NONE_VALUE;
        default: return '0;
      endcase
    end
    return DW'(int'($urandom_range(0, 2000)) - 1000);
  endfunction

  // bias 0 fills the queue, 1 drains it, 2 is balanced
  function automatic logic [1:0] pick_command(input int bias);
    int r;
    int enq_cut;
    r = $urandom_range(0, 99);
    enq_cut = (bias == 0) ? 78 : (bias == 1) ? 20 : 50;
    if (r < enq_cut) return sapq_pkg::CMD_ENQUEUE;
    if (r < 96) return sapq_pkg::CMD_DEQUEUE;
    if (r < 98) return CMD_UNUSED;
    return sapq_pkg::CMD_CLEAR;
  endfunction

  initial begin : rx_pattern
    int step_no;
    int mode;
    int n;
    step_no = 0;
    do @(posedge clk); while (rst);
    forever begin
      step_no++;
      if (step_no % 150 == 40) begin
        // long hold-off so the output register fills and cmd_ready drops
        res_ready <= 1'b0;
        repeat (120) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 9);
        n    = $urandom_range(1, 30);
        repeat (n) begin
          if (mode < 4) res_ready <= 1'b1;
          else if (mode < 8) res_ready <= ($urandom_range(0, 2) != 0);
          else res_ready <= ($urandom_range(0, 3) == 0);
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int sent;
    int blen;
    int bias;
    bit paused;
    do @(posedge clk); while (rst);

    offer(sapq_pkg::CMD_DEQUEUE, $urandom);
    offer(CMD_UNUSED, $urandom);
    offer(sapq_pkg::CMD_ENQUEUE, 32'sh7FFF_FFFF);
    offer(sapq_pkg::CMD_ENQUEUE, 32'sh8000_0000);
    offer(sapq_pkg::CMD_ENQUEUE, sapq_pkg::NONE_VALUE);
    offer(sapq_pkg::CMD_ENQUEUE, '0);
    offer(sapq_pkg::CMD_ENQUEUE, '0);
    for (int i = 0; i < QDEPTH - 5; i++)
      offer(sapq_pkg::CMD_ENQUEUE,
            (i % 2 == 0) ? DW'($urandom) : DW'(int'($urandom_range(0, 6)) - 3));
    offer(sapq_pkg::CMD_ENQUEUE, 32'sd5);
    offer(sapq_pkg::CMD_DEQUEUE, $urandom);
    offer(CMD_UNUSED, $urandom);
    offer(sapq_pkg::CMD_CLEAR, $urandom);
    offer(sapq_pkg::CMD_DEQUEUE, $urandom);
    wait_drained();

    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      blen = $urandom_range(1, 32);
      bias = $urandom_range(0, 2);
      repeat (blen) begin
        offer(pick_command(bias), pick_value());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
